/* design/chroma_box_downsampler_defines.svh */
// ----------------------------------------------------------------------------
// chroma box downsampler assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CHROMA_BOX_DOWNSAMPLER_DEFINES_SVH
`define CHROMA_BOX_DOWNSAMPLER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define CBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg
// shared types, constants and tables of the chroma box downsampler
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int MAX_FACTOR  = 4;
   localparam int BLOCK_SIZE  = 8;
   localparam int BLK_SHIFT   = $clog2(BLOCK_SIZE);
   localparam int FACTOR_W    = 3;
   localparam int SAMPLE_W    = 8;
   localparam int POS_W       = 5;
   localparam int EXT_W       = FACTOR_W + BLK_SHIFT;
   localparam int BOX_CNT_W   = $clog2(MAX_FACTOR);
   localparam int NUM_SUMS    = MAX_FACTOR * BLOCK_SIZE;
   localparam int SUM_IDX_W   = $clog2(NUM_SUMS);
   localparam int SUM_W       = 12;
   localparam int BOX_N_W     = 2 * FACTOR_W;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;
   localparam int REG_IDX_W   = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_LUMA_H   = 2'd0,
      REG_LUMA_V   = 2'd1,
      REG_CHROMA_H = 2'd2,
      REG_CHROMA_V = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_DIVIDE = 1'b1
   } state_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] luma_h;
      logic [FACTOR_W-1:0] luma_v;
      logic [FACTOR_W-1:0] chroma_h;
      logic [FACTOR_W-1:0] chroma_v;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit_ready;
   } status_type;

   // samples per box side: luma factor over chroma factor, valid pairs only
   function automatic logic [FACTOR_W-1:0] box_div(input logic [FACTOR_W-1:0] luma,
                                                   input logic [FACTOR_W-1:0] chroma);
      logic [FACTOR_W-1:0] res;
      res = FACTOR_W'(1);
      if (luma == FACTOR_W'(4) && chroma == FACTOR_W'(1))
         res = FACTOR_W'(4);
      else if (luma == FACTOR_W'(3) && chroma == FACTOR_W'(1))
         res = FACTOR_W'(3);
      else if ((luma == FACTOR_W'(4) && chroma == FACTOR_W'(2)) ||
               (luma == FACTOR_W'(2) && chroma == FACTOR_W'(1)))
         res = FACTOR_W'(2);
      return res;
   endfunction

   // ceil(2^17 / n) for every possible box size
   function automatic logic [RECIP_W-1:0] recip(input logic [BOX_N_W-1:0] n);
      logic [RECIP_W-1:0] res;
      case (n)
         BOX_N_W'(1):  res = RECIP_W'(131072);
         BOX_N_W'(2):  res = RECIP_W'(65536);
         BOX_N_W'(3):  res = RECIP_W'(43691);
         BOX_N_W'(4):  res = RECIP_W'(32768);
         BOX_N_W'(6):  res = RECIP_W'(21846);
         BOX_N_W'(8):  res = RECIP_W'(16384);
         BOX_N_W'(9):  res = RECIP_W'(14564);
         BOX_N_W'(12): res = RECIP_W'(10923);
         BOX_N_W'(16): res = RECIP_W'(8192);
         default:      res = '0;
      endcase
      return res;
   endfunction

endpackage

/* design/cbd_req_if.sv */
// ----------------------------------------------------------------------------
// cbd_req_if
// request channel carrying one chroma sample
// ----------------------------------------------------------------------------
interface cbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [cbd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* design/cbd_rsp_if.sv */
// ----------------------------------------------------------------------------
// cbd_rsp_if
// result channel carrying one box average and its position
// ----------------------------------------------------------------------------
interface cbd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cbd_pkg::SAMPLE_W-1:0] average;
   logic [cbd_pkg::POS_W-1:0]    out_row;
   logic [cbd_pkg::POS_W-1:0]    out_col;
   logic                         last_of_mcu;

   modport source (output valid, output average, output out_row, output out_col,
                   output last_of_mcu, input ready);
   modport sink (input valid, input average, input out_row, input out_col,
                 input last_of_mcu, output ready);
endinterface

/* design/cbd_csr.sv */
// ----------------------------------------------------------------------------
// cbd_csr
// sampling factor registers behind the apb-style port
// ----------------------------------------------------------------------------
module cbd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cbd_pkg::ADDR_W-1:0]  paddr,
   input  logic [cbd_pkg::DATA_W-1:0]  pwdata,
   output logic [cbd_pkg::DATA_W-1:0]  prdata,
   output cbd_pkg::cfg_type            cfg,
   output logic                        restart
);
   import cbd_pkg::*;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                wr_en;
   csr_index_type       reg_idx;
   logic [FACTOR_W-1:0] wr_val;
   logic [FACTOR_W-1:0] rd_val;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = csr_index_type'(paddr[ADDR_W-1:2]);
   assign wr_val  = pwdata[FACTOR_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LUMA_H:   cfg_in.luma_h   = wr_val;
            REG_LUMA_V:   cfg_in.luma_v   = wr_val;
            REG_CHROMA_H: cfg_in.chroma_h = wr_val;
            REG_CHROMA_V: cfg_in.chroma_v = wr_val;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LUMA_H:   rd_val = cfg_ff.luma_h;
         REG_LUMA_V:   rd_val = cfg_ff.luma_v;
         REG_CHROMA_H: rd_val = cfg_ff.chroma_h;
         REG_CHROMA_V: rd_val = cfg_ff.chroma_v;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{luma_h: FACTOR_W'(1), luma_v: FACTOR_W'(1),
                     chroma_h: FACTOR_W'(1), chroma_v: FACTOR_W'(1)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // every address decodes to a register, so every write restarts the mcu
   assign restart = wr_en;
   assign prdata  = DATA_W'(rd_val);
   assign cfg     = cfg_ff;
endmodule

/* design/cbd_ctrl.sv */
// ----------------------------------------------------------------------------
// cbd_ctrl
// request/result sequencing and result valid flag
// ----------------------------------------------------------------------------
module cbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cbd_pkg::status_type  status,
   output cbd_pkg::cmd_type     cmd
);
   import cbd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.emit_ready)
               state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (out_free)
               state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIVIDE: begin
            cmd.load_out = out_free;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/cbd_datapath.sv */
// ----------------------------------------------------------------------------
// cbd_datapath
// position counters, box accumulators, reciprocal divide and result register
// ----------------------------------------------------------------------------
module cbd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cbd_pkg::cfg_type              cfg,
   input  logic                          restart,
   input  cbd_pkg::cmd_type              cmd,
   output cbd_pkg::status_type           status,
   input  logic [cbd_pkg::SAMPLE_W-1:0]  sample,
   output logic [cbd_pkg::SAMPLE_W-1:0]  average,
   output logic [cbd_pkg::POS_W-1:0]     out_row,
   output logic [cbd_pkg::POS_W-1:0]     out_col,
   output logic                          last_of_mcu
);
   import cbd_pkg::*;

   // sample position in the mcu and in the current box
   logic [POS_W-1:0]     in_col_ff, in_col_in;
   logic [POS_W-1:0]     in_row_ff, in_row_in;
   logic [BOX_CNT_W-1:0] hcnt_ff, hcnt_in;
   logic [BOX_CNT_W-1:0] vcnt_ff, vcnt_in;
   logic [POS_W-1:0]     oc_ff, oc_in;
   logic [POS_W-1:0]     orr_ff, orr_in;

   logic [SUM_W-1:0]     sums_ff [NUM_SUMS];
   logic [SUM_W-1:0]     sum_in;
   logic [SUM_W-1:0]     sum_cur;

   logic [SUM_W-1:0]     held_sum_ff;
   logic [RECIP_W-1:0]   recip_ff;
   logic [POS_W-1:0]     held_row_ff, held_col_ff;
   logic                 held_last_ff;

   logic [SAMPLE_W-1:0]  average_ff;
   logic [POS_W-1:0]     out_row_ff, out_col_ff;
   logic                 last_ff;

   logic [FACTOR_W-1:0]  h_div, v_div;
   logic [BOX_N_W-1:0]   box_n;
   logic [EXT_W-1:0]     mcu_w, mcu_h, out_cols, out_rows;
   logic                 luma_ok, chroma_ok, in_range, box_first, h_end, v_end;
   logic                 col_end, row_end, use_sample, sum_we, mcu_last;
   logic [PROD_W-1:0]    product;

   assign h_div = box_div(cfg.luma_h, cfg.chroma_h);
   assign v_div = box_div(cfg.luma_v, cfg.chroma_v);
   assign box_n = BOX_N_W'(h_div) * BOX_N_W'(v_div);

   assign luma_ok = cfg.luma_h != '0 && cfg.luma_h <= FACTOR_W'(MAX_FACTOR) &&
                    cfg.luma_v != '0 && cfg.luma_v <= FACTOR_W'(MAX_FACTOR);
   assign chroma_ok = cfg.chroma_h != '0 && cfg.chroma_h <= cfg.luma_h &&
                      cfg.chroma_v != '0 && cfg.chroma_v <= cfg.luma_v;

   assign mcu_w    = EXT_W'(cfg.luma_h) << BLK_SHIFT;
   assign mcu_h    = EXT_W'(cfg.luma_v) << BLK_SHIFT;
   assign out_cols = EXT_W'(cfg.chroma_h) << BLK_SHIFT;
   assign out_rows = EXT_W'(cfg.chroma_v) << BLK_SHIFT;

   assign col_end   = EXT_W'(in_col_ff) == mcu_w - EXT_W'(1);
   assign row_end   = EXT_W'(in_row_ff) == mcu_h - EXT_W'(1);
   assign h_end     = FACTOR_W'(hcnt_ff) == h_div - FACTOR_W'(1);
   assign v_end     = FACTOR_W'(vcnt_ff) == v_div - FACTOR_W'(1);
   assign box_first = hcnt_ff == '0 && vcnt_ff == '0;
   assign in_range  = EXT_W'(oc_ff) < out_cols && EXT_W'(orr_ff) < out_rows;
   assign mcu_last  = EXT_W'(orr_ff) == out_rows - EXT_W'(1) &&
                      EXT_W'(oc_ff) == out_cols - EXT_W'(1);

   assign use_sample        = luma_ok && chroma_ok && in_range;
   assign status.emit_ready = use_sample && h_end && v_end;
   assign sum_we            = cmd.accept && use_sample;

   assign sum_cur = sums_ff[oc_ff[SUM_IDX_W-1:0]];
   assign sum_in  = box_first ? SUM_W'(sample) : sum_cur + SUM_W'(sample);

   // raster walk with box sub-counters
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      hcnt_in   = hcnt_ff;
      vcnt_in   = vcnt_ff;
      oc_in     = oc_ff;
      orr_in    = orr_ff;
      if (cmd.accept && luma_ok) begin
         if (col_end) begin
            in_col_in = '0;
            hcnt_in   = '0;
            oc_in     = '0;
            if (row_end) begin
               in_row_in = '0;
               vcnt_in   = '0;
               orr_in    = '0;
            end else begin
               in_row_in = in_row_ff + POS_W'(1);
               if (v_end) begin
                  vcnt_in = '0;
                  orr_in  = orr_ff + POS_W'(1);
               end else begin
                  vcnt_in = vcnt_ff + BOX_CNT_W'(1);
               end
            end
         end else begin
            in_col_in = in_col_ff + POS_W'(1);
            if (h_end) begin
               hcnt_in = '0;
               oc_in   = oc_ff + POS_W'(1);
            end else begin
               hcnt_in = hcnt_ff + BOX_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         hcnt_ff   <= '0;
         vcnt_ff   <= '0;
         oc_ff     <= '0;
         orr_ff    <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         hcnt_ff   <= hcnt_in;
         vcnt_ff   <= vcnt_in;
         oc_ff     <= oc_in;
         orr_ff    <= orr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we)
         sums_ff[oc_ff[SUM_IDX_W-1:0]] <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && status.emit_ready) begin
         held_sum_ff  <= sum_in;
         recip_ff     <= recip(box_n);
         held_row_ff  <= orr_ff;
         held_col_ff  <= oc_ff;
         held_last_ff <= mcu_last;
      end
   end

   // floor division by the box size through its reciprocal
   assign product = PROD_W'(held_sum_ff) * PROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         average_ff <= product[RECIP_SHIFT +: SAMPLE_W];
         out_row_ff <= held_row_ff;
         out_col_ff <= held_col_ff;
         last_ff    <= held_last_ff;
      end
   end

   assign average     = average_ff;
   assign out_row     = out_row_ff;
   assign out_col     = out_col_ff;
   assign last_of_mcu = last_ff;
endmodule

/* design/chroma_box_downsampler.sv */
// ----------------------------------------------------------------------------
// chroma_box_downsampler
// jpeg chroma subsampling of one mcu by box averaging
// ----------------------------------------------------------------------------
//  channel   role       handshake                 payload
//  req_chan  sink       valid/ready               sample
//  rsp_chan  source     valid/ready               average, out_row, out_col,
//                                                 last_of_mcu
//  csr_*     apb slave  psel/penable, pready=1    four sampling factor regs
//
//  a request that completes no box is taken in the idle state alone; one that
//  completes a box also passes the divide state, the reciprocal multiply into
//  the result register; the divide state waits while the result register
//  still holds an untaken result
//  synchronous reset clears the counters, controller and result valid and sets
//  all factors to 1; the box accumulators are not cleared
//  a register write restarts the mcu at row 0, column 0
// ----------------------------------------------------------------------------
module chroma_box_downsampler (
   input  logic                        clock,
   input  logic                        reset,
   cbd_req_if.sink                     req_chan,
   cbd_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cbd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cbd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [cbd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import cbd_pkg::*;

   cfg_type    cfg;
   logic       restart;
   cmd_type    cmd;
   status_type status;

   // register file, every write also restarts the walk through the mcu
   cbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg),
      .restart (restart)
   );

   // no wait states on the register port
   assign csr_pready = 1'b1;

   // controller: idle takes requests, divide loads the result register
   cbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: counters, accumulator row, divide and result payload
   cbd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .restart     (restart),
      .cmd         (cmd),
      .status      (status),
      .sample      (req_chan.sample),
      .average     (rsp_chan.average),
      .out_row     (rsp_chan.out_row),
      .out_col     (rsp_chan.out_col),
      .last_of_mcu (rsp_chan.last_of_mcu)
   );
endmodule

/* design/cbd_checker.sv */
// ----------------------------------------------------------------------------
// cbd_checker
// port-level checks of the chroma box downsampler, bound to the top level
// ----------------------------------------------------------------------------
`include "chroma_box_downsampler_defines.svh"

module cbd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [cbd_pkg::SAMPLE_W-1:0] rsp_average,
   input logic [cbd_pkg::POS_W-1:0]    rsp_out_row,
   input logic [cbd_pkg::POS_W-1:0]    rsp_out_col,
   input logic                         rsp_last
);
   import cbd_pkg::*;

   // a stalled result keeps its payload
   `CBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last), "result changed while stalled")

   // a fresh result follows the request that closed its box, by way of the divide state
   `CBD_ASSERT_SAME(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a closing request")

   // ready drops only behind an accepted request
   `CBD_ASSERT_SAME(a_ready_drop, $fell(req_ready), $past(req_valid && req_ready), "ready dropped without a request")

   // no result is pending right after reset
   `CBD_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid, "result valid after reset")
endmodule

bind chroma_box_downsampler cbd_checker u_cbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_average (rsp_chan.average),
   .rsp_out_row (rsp_chan.out_row),
   .rsp_out_col (rsp_chan.out_col),
   .rsp_last    (rsp_chan.last_of_mcu)
);
